// File: src/bmalloc_pkg.sv
// ----------------------------------------------------------------------------
// bmalloc_pkg
// shared field widths, request codes and status codes of the bitmap allocator
// ----------------------------------------------------------------------------
package bmalloc_pkg;

    // item field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 19;
    localparam int STATUS_W = 2;
    localparam int RESULT_W = 18;
    localparam int COUNT_W  = 19;

    // stream widths, payload padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // request codes
    localparam opcode_t OP_ALLOC = 2'd0;
    localparam opcode_t OP_FREE  = 2'd1;
    localparam opcode_t OP_QUERY = 2'd2;
    localparam opcode_t OP_CLEAR = 2'd3;

    // status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NO_FREE   = 2'd1;
    localparam status_t ST_RANGE     = 2'd2;
    localparam status_t ST_NOT_ALLOC = 2'd3;

endpackage

// File: src/three_level_bitmap_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// three_level_bitmap_id_allocator_unit
// index allocator over a three-level bitmap (top word, middle and leaf memories)
// sequence: allocate walks the top, middle and leaf words; free and query split
//   the index first, and an out-of-range one ends there; clear sweeps both memories
// throughput: one item at a time; the next item can be taken the cycle after the
//   result is registered, which waits while the output register is still full
// reset: a clearing pass over all LEAF_WORDS and MIDDLE_WORDS entries
//   zeroes both memories; s_tready stays low until it is done
// ----------------------------------------------------------------------------
module three_level_bitmap_id_allocator_unit #(
    parameter int WORD_BITS    = 64,
    parameter int MIDDLE_WORDS = 64,
    parameter int LEAF_WORDS   = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bmalloc_pkg::IN_TDATA_W-1:0]  s_tdata,   // index
    input  logic [bmalloc_pkg::IN_TUSER_W-1:0]  s_tuser,   // opcode
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmalloc_pkg::OUT_TDATA_W-1:0] m_tdata    // status, result_index,
                                                           // in_use, live_count
);
    import bmalloc_pkg::*;

    // geometry
    localparam int BW       = $clog2(WORD_BITS);
    localparam int EFF_MID  = (MIDDLE_WORDS < WORD_BITS) ? MIDDLE_WORDS : WORD_BITS;
    localparam int EFF_LEAF = (LEAF_WORDS < EFF_MID * WORD_BITS) ? LEAF_WORDS
                                                                 : EFF_MID * WORD_BITS;
    localparam int CAPACITY = EFF_LEAF * WORD_BITS;
    localparam int FULLM    = EFF_LEAF / WORD_BITS;   // middle words with all bits usable
    localparam int REMB     = EFF_LEAF % WORD_BITS;   // usable bits of the partial word
    localparam int NUM_MID  = FULLM + ((REMB != 0) ? 1 : 0);
    localparam int LAW      = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
    localparam int MAW      = (MIDDLE_WORDS > 1) ? $clog2(MIDDLE_WORDS) : 1;
    localparam int SWEEP    = (LEAF_WORDS > MIDDLE_WORDS) ? LEAF_WORDS : MIDDLE_WORDS;
    localparam int CW       = (SWEEP > 1) ? $clog2(SWEEP) : 1;
    localparam int LIW      = 2 * BW;                 // width of a computed leaf number

    localparam logic [63:0] ONES64 = {64{1'b1}};
    localparam logic [WORD_BITS-1:0] TOP_USED  = WORD_BITS'(ONES64 >> (64 - NUM_MID));
    localparam logic [WORD_BITS-1:0] TOP_PAD   = ~TOP_USED;
    localparam logic [WORD_BITS-1:0] LAST_MASK = (REMB == 0) ? '0
                                               : WORD_BITS'(ONES64 >> (64 - REMB));
    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    // index split by reciprocal multiply, exact for every input value
    localparam int QW = 20 - BW;                      // index / WORD_BITS
    localparam int K1 = INDEX_W + BW;
    localparam int K2 = QW + BW;
    localparam longint unsigned M1 = ((64'd1 << K1) + 64'(WORD_BITS) - 64'd1)
                                     / 64'(WORD_BITS);
    localparam longint unsigned M2 = ((64'd1 << K2) + 64'(WORD_BITS) - 64'd1)
                                     / 64'(WORD_BITS);
    localparam int P1W = INDEX_W + 21;
    localparam int P2W = QW + 21;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AL_TOP  = 4'd1;
    localparam logic [3:0] S_AL_MID  = 4'd2;
    localparam logic [3:0] S_AL_LEAF = 4'd3;
    localparam logic [3:0] S_DV1     = 4'd4;
    localparam logic [3:0] S_DV2     = 4'd5;
    localparam logic [3:0] S_FQ_LEAF = 4'd6;
    localparam logic [3:0] S_FQ_MID  = 4'd7;
    localparam logic [3:0] S_CLR     = 4'd8;

    // usable leaf words under middle word m, the rest count as full
    function automatic logic [WORD_BITS-1:0] mid_mask(input logic [BW-1:0] m);
        logic [WORD_BITS-1:0] mask;
        if (32'(m) < FULLM)
            mask = '1;
        else if (32'(m) == FULLM)
            mask = LAST_MASK;
        else
            mask = '0;
        return mask;
    endfunction

    // position of the lowest clear bit
    function automatic logic [BW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] hot;
        logic [BW-1:0]        pos;
        hot = ~w & (w + WORD_BITS'(1));
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (hot[i])
                pos = pos | BW'(i);
        end
        return pos;
    endfunction

    // control registers
    logic [3:0]            state_reg, state_next;
    logic [WORD_BITS-1:0]  top_reg, top_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [CW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  clr_resp_reg, clr_resp_next;
    logic                  m_tvalid_reg;

    // payload registers
    opcode_t               op_reg, op_next;
    logic [INDEX_W-1:0]    idx_reg, idx_next;
    logic [BW-1:0]         b1_reg, b1_next;
    logic [BW-1:0]         b2_reg, b2_next;
    logic [LAW-1:0]        leaf_idx_reg, leaf_idx_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic [BW-1:0]         mid_reg, mid_next;
    logic [BW-1:0]         mb_reg, mb_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // memories and their ports
    logic [WORD_BITS-1:0]  leaf_mem [LEAF_WORDS];
    logic [WORD_BITS-1:0]  mid_mem  [MIDDLE_WORDS];
    logic [WORD_BITS-1:0]  leaf_rd_reg, mid_rd_reg;
    logic                  leaf_re, leaf_we, mid_re, mid_we;
    logic [LAW-1:0]        leaf_raddr, leaf_waddr;
    logic [MAW-1:0]        mid_raddr, mid_waddr;
    logic [WORD_BITS-1:0]  leaf_wdata, mid_wdata;

    // result being finished this cycle
    logic                  out_free;
    logic                  fin;
    status_t               fin_status;
    logic [RESULT_W-1:0]   fin_grant;
    logic                  fin_inuse;

    // datapath
    logic [WORD_BITS-1:0]  top_word, mid_word, leaf_set, mid_set;
    logic [BW-1:0]         b1_pick, b2_pick, b3_pick;
    logic [LIW-1:0]        leaf_pick;
    logic [RESULT_W-1:0]   grant;
    logic [P1W-1:0]        prod1;
    logic [P2W-1:0]        prod2;
    logic [INDEX_W-1:0]    idx_rem;
    logic [QW-1:0]         q_rem;
    logic                  leaf_hit;
    logic                  in_range;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // allocate walk: top word, then middle word, then leaf word
    assign top_word  = top_reg | TOP_PAD;
    assign b1_pick   = lowest_zero(top_word);
    assign mid_word  = mid_rd_reg | ~mid_mask(b1_reg);
    assign b2_pick   = lowest_zero(mid_word);
    assign leaf_pick = LIW'(b1_reg) * LIW'(WORD_BITS) + LIW'(b2_pick);
    assign b3_pick   = lowest_zero(leaf_rd_reg);
    assign leaf_set  = leaf_rd_reg | (WORD_BITS'(1) << b3_pick);
    assign mid_set   = mid_rd_reg | (WORD_BITS'(1) << b2_reg);
    assign grant     = RESULT_W'(leaf_idx_reg) * RESULT_W'(WORD_BITS) + RESULT_W'(b3_pick);

    // free / query: leaf word = index / WORD_BITS, middle word = leaf / WORD_BITS
    assign in_range = 32'(idx_reg) < CAPACITY;
    assign prod1    = P1W'(idx_reg) * P1W'(M1);
    assign prod2    = P2W'(q_reg) * P2W'(M2);
    assign idx_rem  = idx_reg - INDEX_W'(q_reg) * INDEX_W'(WORD_BITS);
    assign q_rem    = q_reg - QW'(mid_reg) * QW'(WORD_BITS);
    assign leaf_hit = leaf_rd_reg[bit_reg];

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        leaf_idx_next = leaf_idx_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        mid_next      = mid_reg;
        mb_next       = mb_reg;
        leaf_re       = 1'b0;
        leaf_raddr    = '0;
        leaf_we       = 1'b0;
        leaf_waddr    = '0;
        leaf_wdata    = '0;
        mid_re        = 1'b0;
        mid_raddr     = '0;
        mid_we        = 1'b0;
        mid_waddr     = '0;
        mid_wdata     = '0;
        fin           = 1'b0;
        fin_status    = ST_OK;
        fin_grant     = '0;
        fin_inuse     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser[OPCODE_W-1:0];
                    idx_next = s_tdata[INDEX_W-1:0];
                    case (s_tuser[OPCODE_W-1:0])
                        OP_ALLOC: state_next = S_AL_TOP;
                        OP_FREE,
                        OP_QUERY: state_next = S_DV1;
                        default:
                        begin
                            state_next    = S_CLR;
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                        end
                    endcase
                end
            end

            S_AL_TOP:
            begin
                if (top_word == WORD_ONES)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_NO_FREE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    b1_next    = b1_pick;
                    mid_re     = 1'b1;
                    mid_raddr  = MAW'(b1_pick);
                    state_next = S_AL_MID;
                end
            end

            S_AL_MID:
            begin
                if (mid_word == WORD_ONES)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_NO_FREE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    b2_next       = b2_pick;
                    leaf_idx_next = LAW'(leaf_pick);
                    leaf_re       = 1'b1;
                    leaf_raddr    = LAW'(leaf_pick);
                    state_next    = S_AL_LEAF;
                end
            end

            S_AL_LEAF:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    if (leaf_rd_reg == WORD_ONES)
                    begin
                        fin_status = ST_NO_FREE;
                    end
                    else
                    begin
                        fin_grant  = grant;
                        leaf_we    = 1'b1;
                        leaf_waddr = leaf_idx_reg;
                        leaf_wdata = leaf_set;
                        // leaf word filled up: mark it in the middle word, and
                        // the middle word in the top word when that fills too
                        if (leaf_set == WORD_ONES)
                        begin
                            mid_we    = 1'b1;
                            mid_waddr = MAW'(b1_reg);
                            mid_wdata = mid_set;
                            if ((mid_set | ~mid_mask(b1_reg)) == WORD_ONES)
                                top_next = top_reg | (WORD_BITS'(1) << b1_reg);
                        end
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end

            S_DV1:
            begin
                if (!in_range)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_RANGE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    q_next     = QW'(prod1 >> K1);
                    state_next = S_DV2;
                end
            end

            S_DV2:
            begin
                bit_next      = idx_rem[BW-1:0];
                mid_next      = BW'(prod2 >> K2);
                leaf_idx_next = LAW'(q_reg);
                leaf_re       = 1'b1;
                leaf_raddr    = LAW'(q_reg);
                state_next    = S_FQ_LEAF;
            end

            S_FQ_LEAF:
            begin
                if (op_reg == OP_QUERY || !leaf_hit)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        fin_inuse  = (op_reg == OP_QUERY) && leaf_hit;
                        fin_status = (op_reg == OP_QUERY) ? ST_OK : ST_NOT_ALLOC;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    leaf_we    = 1'b1;
                    leaf_waddr = leaf_idx_reg;
                    leaf_wdata = leaf_rd_reg & ~(WORD_BITS'(1) << bit_reg);
                    mb_next    = q_rem[BW-1:0];
                    mid_re     = 1'b1;
                    mid_raddr  = MAW'(mid_reg);
                    state_next = S_FQ_MID;
                end
            end

            S_FQ_MID:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    mid_we     = 1'b1;
                    mid_waddr  = MAW'(mid_reg);
                    mid_wdata  = mid_rd_reg & ~(WORD_BITS'(1) << mb_reg);
                    top_next   = top_reg & ~(WORD_BITS'(1) << mid_reg);
                    count_next = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;
                    state_next = S_IDLE;
                end
            end

            S_CLR:
            begin
                // one leaf entry and one middle entry per cycle, each while its memory has entries left
                if (32'(clr_cnt_reg) < LEAF_WORDS)
                begin
                    leaf_we    = 1'b1;
                    leaf_waddr = clr_cnt_reg[LAW-1:0];
                end
                if (32'(clr_cnt_reg) < MIDDLE_WORDS)
                begin
                    mid_we    = 1'b1;
                    mid_waddr = clr_cnt_reg[MAW-1:0];
                end
                if (clr_cnt_reg == CW'(SWEEP - 1))
                begin
                    if (!clr_resp_reg || out_free)
                    begin
                        fin        = clr_resp_reg;
                        top_next   = '0;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            top_reg      <= '0;
            count_reg    <= '0;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            count_reg    <= count_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            if (fin)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        leaf_idx_reg <= leaf_idx_next;
        q_reg        <= q_next;
        bit_reg      <= bit_next;
        mid_reg      <= mid_next;
        mb_reg       <= mb_next;
        if (fin)
            m_tdata_reg <= {count_next, fin_inuse, fin_grant, fin_status};
    end

    // leaf memory, registered read
    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_waddr] <= leaf_wdata;
        if (leaf_re)
            leaf_rd_reg <= leaf_mem[leaf_raddr];
    end

    // middle memory, registered read
    always_ff @(posedge clk)
    begin
        if (mid_we)
            mid_mem[mid_waddr] <= mid_wdata;
        if (mid_re)
            mid_rd_reg <= mid_mem[mid_raddr];
    end

    // live count never passes the number of usable indices
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("live count above capacity");

    // a granted index lies inside the usable range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[STATUS_W-1:0] == ST_OK |->
            32'(m_tdata[STATUS_W +: RESULT_W]) < CAPACITY)
        else $error("granted index out of range");

    // a clear item starts the clearing pass from entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[OPCODE_W-1:0] == OP_CLEAR |=>
            state_reg == S_CLR && clr_cnt_reg == '0)
        else $error("clear did not start the sweep");

    // a result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> out_free)
        else $error("result overwrote a pending item");

endmodule
